// ===== hw/rtl/gssn_pkg.sv =====
package gssn_pkg;

  // Fixed-point format of coordinates, settings and sine values
  localparam int unsigned FRAC_BITS = 16;

  localparam int unsigned CFG_W   = 24;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned FC_W    = CFG_W + COORD_W;  // f*c in Q.2F
  localparam int unsigned ANG_W   = FC_W + 1;         // sine argument in Q.2F
  localparam int unsigned SIN_W   = 18;               // sine in Q.F, [-1, 1]
  localparam int unsigned SER_W   = 26;               // one axis series in Q.F
  localparam int unsigned OUT_W   = 48;

  // Argument reduction: offset to make the angle positive, then
  // one compare-subtract of a shifted 2*pi per stage
  localparam int unsigned RED_W = 58;
  localparam int unsigned NRED  = 24;
  localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;
  localparam logic [63:0] TWO_PI_Q2F = TWO_PI_Q60 >> (60 - 2 * FRAC_BITS);
  localparam logic [RED_W-1:0] RED_OFFSET = RED_W'(TWO_PI_Q2F << 22);
  localparam int unsigned Q30_SHIFT = 2 * FRAC_BITS - 30;

  // CORDIC constants in Q.30
  localparam int unsigned CORDIC_W = 34;
  localparam int unsigned FOLD_W   = 36;
  localparam logic signed [FOLD_W-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [FOLD_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [FOLD_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [CORDIC_W-1:0] CORDIC_K_Q30 = 34'sd652032875;
  localparam logic signed [CORDIC_W-1:0] ONE_Q30      = 34'sd1073741824;

  localparam logic signed [CORDIC_W-1:0] ATAN_Q30 [32] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
    34'sd67021687, 34'sd33543516, 34'sd16775851, 34'sd8388437,
    34'sd4194283, 34'sd2097149, 34'sd1048576, 34'sd524288,
    34'sd262144, 34'sd131072, 34'sd65536, 34'sd32768,
    34'sd16384, 34'sd8192, 34'sd4096, 34'sd2048,
    34'sd1024, 34'sd512, 34'sd256, 34'sd128,
    34'sd64, 34'sd32, 34'sd16, 34'sd8,
    34'sd4, 34'sd2, 34'sd1, 34'sd0
  };

  // a/1.17 as (a*100)/117: reciprocal multiply, exact for |a*100| < 2^30
  localparam int unsigned AD_SHIFT = 37;
  localparam logic [30:0] AD_RECIP = 31'd1174691911;

  // Division by 27 four bits a step, reciprocal for the digit
  localparam int unsigned DIV_DIGITS = 15;
  localparam int unsigned DIV_W      = 4 * DIV_DIGITS;

  typedef enum logic [1:0] {
    REG_AMPLITUDE  = 2'd0,
    REG_FREQUENCY  = 2'd1,
    REG_PHASE_GAIN = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
  } point_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] noise_value;
    logic                    saturated;
  } noise_t;

endpackage

// ===== hw/rtl/gssn_sine.sv =====
module gssn_sine #(
  parameter int unsigned ITERATIONS = 18
) (
  input  logic                                   clk_i,
  input  logic signed [gssn_pkg::ANG_W-1:0]      ang_i,
  output logic signed [gssn_pkg::SIN_W-1:0]      sin_o
);

  localparam int unsigned RW = gssn_pkg::RED_W;
  localparam int unsigned CW = gssn_pkg::CORDIC_W;
  localparam int unsigned FW = gssn_pkg::FOLD_W;

  logic [RW-1:0] red_q [gssn_pkg::NRED+1];
  logic signed [CW-1:0] x_q [ITERATIONS+1];
  logic signed [CW-1:0] y_q [ITERATIONS+1];
  logic signed [CW-1:0] z_q [ITERATIONS+1];
  logic signed [FW-1:0] r30, t30, f30;
  logic signed [CW-1:0] yc, yr;
  logic signed [gssn_pkg::SIN_W-1:0] sin_q;

  // offset by a multiple of 2*pi so the angle is positive
  always_ff @(posedge clk_i) begin
    red_q[0] <= RW'(ang_i) + gssn_pkg::RED_OFFSET;
  end

  // restoring reduction modulo 2*pi, one shifted divisor a stage
  for (genvar k = 0; k < gssn_pkg::NRED; k++) begin : g_red
    localparam logic [RW-1:0] Div = RW'(gssn_pkg::TWO_PI_Q2F << (gssn_pkg::NRED - 1 - k));
    always_ff @(posedge clk_i) begin
      if (red_q[k] >= Div) begin
        red_q[k+1] <= red_q[k] - Div;
      end else begin
        red_q[k+1] <= red_q[k];
      end
    end
  end

  // to Q.30, wrap to (-pi, pi], fold into [-pi/2, pi/2]
  always_comb begin
    r30 = FW'(red_q[gssn_pkg::NRED] >> gssn_pkg::Q30_SHIFT);
    t30 = (r30 > gssn_pkg::PI_Q30) ? r30 - gssn_pkg::TWO_PI_Q30 : r30;
    if (t30 > gssn_pkg::HALF_PI_Q30) begin
      f30 = gssn_pkg::PI_Q30 - t30;
    end else if (t30 < -gssn_pkg::HALF_PI_Q30) begin
      f30 = -gssn_pkg::PI_Q30 - t30;
    end else begin
      f30 = t30;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0] <= gssn_pkg::CORDIC_K_Q30;
    y_q[0] <= '0;
    z_q[0] <= CW'(f30);
  end

  // rotation-mode CORDIC, one iteration a stage
  for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
    always_ff @(posedge clk_i) begin
      if (!z_q[i][CW-1]) begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - gssn_pkg::ATAN_Q30[i];
      end else begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + gssn_pkg::ATAN_Q30[i];
      end
    end
  end

  // clamp to [-1, 1] and round to Q.F
  always_comb begin
    if (y_q[ITERATIONS] > gssn_pkg::ONE_Q30) begin
      yc = gssn_pkg::ONE_Q30;
    end else if (y_q[ITERATIONS] < -gssn_pkg::ONE_Q30) begin
      yc = -gssn_pkg::ONE_Q30;
    end else begin
      yc = y_q[ITERATIONS];
    end
    yr = (yc + (CW'(1) <<< (29 - gssn_pkg::FRAC_BITS))) >>> (30 - gssn_pkg::FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    sin_q <= yr[gssn_pkg::SIN_W-1:0];
  end

  assign sin_o = sin_q;

endmodule

// ===== hw/rtl/gardner_sine_series_noise_3d_unit.sv =====
// Gardner sine-series solid noise, one 3-D point per beat.
// Input: item_i (coord_x/y/z, signed Q16.16) is taken at a rising edge with
// start_i high and busy_o low. busy_o stays low: a point may enter every cycle.
// Output: result_o (noise_value Q32.16, saturated flag) is valid for exactly
// one cycle while done_o is high; results leave in input order.
// Each sine is a pipeline of an offset register, 24 reduction stages (modulo
// 2*pi), a CORDIC load register, one stage per CORDIC iteration and an output
// register; the second sine of an axis waits on the first sine of its
// neighbor, so two of these are in series. Throughput: one point per cycle.
// Settings: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 amplitude, 1 frequency, 2 phase gain, each signed Q8.16); other
// indexes are ignored. Write only while no point is in flight.
// Reset clears the settings to 2.5, 0.7 and 1.4 and drops all points in
// flight. The receiver cannot stall; done_o is a strobe.
module gardner_sine_series_noise_3d_unit #(
  parameter int unsigned SINE_ITERATIONS = 18
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  gssn_pkg::point_t              item_i,
  output logic                          done_o,
  output gssn_pkg::noise_t              result_o,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [gssn_pkg::CFG_W-1:0]    cfg_data_i
);

  localparam int unsigned LSIN = gssn_pkg::NRED + SINE_ITERATIONS + 3;
  localparam int unsigned DQ   = LSIN - 16;
  localparam int unsigned DS   = LSIN + 2;
  localparam int unsigned LAT  = 2 * LSIN + 9;
  localparam int unsigned F    = gssn_pkg::FRAC_BITS;
  localparam int unsigned SW   = gssn_pkg::SIN_W;
  localparam int unsigned AW   = gssn_pkg::ANG_W;
  localparam int unsigned RW   = gssn_pkg::SER_W;
  localparam int unsigned OW   = gssn_pkg::OUT_W;
  localparam int unsigned PXY_W = 2 * RW - F;
  localparam int unsigned PM_W  = PXY_W + RW - F;

  // settings
  logic signed [gssn_pkg::CFG_W-1:0] amplitude_q, frequency_q, phase_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amplitude_q  <= 24'sd163840;
      frequency_q  <= 24'sd45875;
      phase_gain_q <= 24'sd91750;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gssn_pkg::REG_AMPLITUDE:  amplitude_q  <= cfg_data_i;
        gssn_pkg::REG_FREQUENCY:  frequency_q  <= cfg_data_i;
        gssn_pkg::REG_PHASE_GAIN: phase_gain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // a/1.17, recomputed continuously from the amplitude setting
  logic        ad_neg1_q, ad_neg2_q;
  logic [30:0] ad_m100_q;
  logic [61:0] ad_prod_q;
  logic signed [gssn_pkg::CFG_W-1:0] ad_q;
  logic [gssn_pkg::CFG_W-1:0] a_abs;
  logic [gssn_pkg::CFG_W:0]   ad_mag;

  assign a_abs  = amplitude_q[gssn_pkg::CFG_W-1] ? -amplitude_q : amplitude_q;
  assign ad_mag = ad_prod_q[gssn_pkg::AD_SHIFT +: gssn_pkg::CFG_W+1];

  always_ff @(posedge clk_i) begin
    ad_neg1_q <= amplitude_q[gssn_pkg::CFG_W-1];
    ad_m100_q <= 31'(a_abs) * 31'd100;
    ad_neg2_q <= ad_neg1_q;
    ad_prod_q <= 62'(ad_m100_q) * 62'(gssn_pkg::AD_RECIP);
    ad_q      <= ad_neg2_q ? -gssn_pkg::CFG_W'(ad_mag) : gssn_pkg::CFG_W'(ad_mag);
  end

  // valid chain; the pipeline never stalls
  logic [LAT:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-1:0], start_i};
    end
  end

  assign busy_o = 1'b0;

  // input beat
  logic signed [gssn_pkg::COORD_W-1:0] coord_q [3];

  always_ff @(posedge clk_i) begin
    coord_q[0] <= item_i.coord_x;
    coord_q[1] <= item_i.coord_y;
    coord_q[2] <= item_i.coord_z;
  end

  logic signed [SW-1:0] sa_s [3];
  logic signed [RW-1:0] ser_q [3];

  // per-axis lanes
  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int unsigned Nb = (i == 0) ? 2 : i - 1;

    logic signed [gssn_pkg::FC_W-1:0] fc_q;
    logic [gssn_pkg::DIV_W-1:0] num_q [gssn_pkg::DIV_DIGITS+1];
    logic [4:0] rem_q [gssn_pkg::DIV_DIGITS+1];
    logic       dneg_q [gssn_pkg::DIV_DIGITS+1];
    logic signed [AW-1:0] quo_q;
    logic signed [AW-1:0] qdly_q [DQ];
    logic signed [SW-1:0] sdly_q [DS];
    logic signed [gssn_pkg::CFG_W+SW-1:0] ps_q, m1_q, m2_q;
    logic signed [AW-1:0] ang2_q;
    logic signed [SW-1:0] sb_s;
    logic signed [gssn_pkg::FC_W-1:0] fc_abs;
    logic signed [gssn_pkg::CFG_W+SW:0] sum;
    logic signed [AW-1:0] qmag;

    // f*c in Q.2F
    always_ff @(posedge clk_i) begin
      fc_q <= frequency_q * coord_q[i];
    end

    gssn_sine #(.ITERATIONS(SINE_ITERATIONS)) u_sine_a (
      .clk_i (clk_i),
      .ang_i (AW'(fc_q)),
      .sin_o (sa_s[i])
    );

    // (f*c*20)/27 toward zero: magnitude, then long division by 27
    assign fc_abs = fc_q[gssn_pkg::FC_W-1] ? -fc_q : fc_q;

    always_ff @(posedge clk_i) begin
      num_q[0]  <= gssn_pkg::DIV_W'(fc_abs[gssn_pkg::FC_W-2:0]) * gssn_pkg::DIV_W'(20);
      rem_q[0]  <= '0;
      dneg_q[0] <= fc_q[gssn_pkg::FC_W-1];
    end

    for (genvar j = 0; j < gssn_pkg::DIV_DIGITS; j++) begin : g_div
      logic [8:0]  val;
      logic [19:0] est;
      logic [3:0]  qd;
      assign val = {rem_q[j], num_q[j][gssn_pkg::DIV_W-1 -: 4]};
      assign est = 20'(val) * 20'd1214;
      assign qd  = est[18:15];
      always_ff @(posedge clk_i) begin
        rem_q[j+1]  <= 5'(val - 9'(qd) * 9'd27);
        num_q[j+1]  <= {num_q[j][gssn_pkg::DIV_W-5:0], qd};
        dneg_q[j+1] <= dneg_q[j];
      end
    end

    assign qmag = AW'(num_q[gssn_pkg::DIV_DIGITS][AW-2:0]);

    always_ff @(posedge clk_i) begin
      quo_q <= dneg_q[gssn_pkg::DIV_DIGITS] ? -qmag : qmag;
    end

    // hold the quotient and own sine until the partner values arrive
    always_ff @(posedge clk_i) begin
      qdly_q[0] <= quo_q;
      sdly_q[0] <= sa_s[i];
      for (int k = 1; k < DQ; k++) qdly_q[k] <= qdly_q[k-1];
      for (int k = 1; k < DS; k++) sdly_q[k] <= sdly_q[k-1];
    end

    // second angle: f*c/1.35 + p*s_neighbor
    always_ff @(posedge clk_i) begin
      ps_q   <= phase_gain_q * sa_s[Nb];
      ang2_q <= qdly_q[DQ-1] + AW'(ps_q);
    end

    gssn_sine #(.ITERATIONS(SINE_ITERATIONS)) u_sine_b (
      .clk_i (clk_i),
      .ang_i (ang2_q),
      .sin_o (sb_s)
    );

    // series a*s + (a/1.17)*s2, rounded to Q.F
    assign sum = (gssn_pkg::CFG_W+SW+1)'(m1_q) + (gssn_pkg::CFG_W+SW+1)'(m2_q)
               + ((gssn_pkg::CFG_W+SW+1)'(1) <<< (F - 1));

    always_ff @(posedge clk_i) begin
      m1_q     <= amplitude_q * sdly_q[DS-1];
      m2_q     <= ad_q * sb_s;
      ser_q[i] <= RW'(sum >>> F);
    end
  end

  // product of the three series on magnitudes
  logic [RW-1:0]    mag_q [3];
  logic [RW-1:0]    mz_q;
  logic [PXY_W-1:0] pxy_q;
  logic [PM_W-1:0]  pm_q;
  logic             neg1_q, neg2_q, neg3_q;
  logic [OW:0]      lim, mag_ext;
  logic             sat;
  logic [OW-1:0]    clip;
  gssn_pkg::noise_t res_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      mag_q[k] <= ser_q[k][RW-1] ? -ser_q[k] : ser_q[k];
    end
    neg1_q <= ser_q[0][RW-1] ^ ser_q[1][RW-1] ^ ser_q[2][RW-1];
    pxy_q  <= PXY_W'((2*RW)'(mag_q[0]) * (2*RW)'(mag_q[1]) >> F);
    mz_q   <= mag_q[2];
    neg2_q <= neg1_q;
    pm_q   <= PM_W'((PXY_W+RW)'(pxy_q) * (PXY_W+RW)'(mz_q) >> F);
    neg3_q <= neg2_q;
  end

  // saturate to the signed output range
  always_comb begin
    lim     = neg3_q ? ((OW+1)'(1) << (OW - 1)) : (((OW+1)'(1) << (OW - 1)) - 1'b1);
    mag_ext = (OW+1)'(pm_q);
    sat     = mag_ext > lim;
    clip    = sat ? lim[OW-1:0] : mag_ext[OW-1:0];
  end

  always_ff @(posedge clk_i) begin
    res_q.noise_value <= neg3_q ? -clip : clip;
    res_q.saturated   <= sat;
  end

  assign done_o   = vld_q[LAT];
  assign result_o = res_q;

endmodule
